### hdl/assert_macros.svh
// Assertion helpers used by the checker file.
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication: whenever ante holds, cons holds in the cycle after.
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

### hdl/mm8_pkg.sv
// ---------------------------------------------------------------------------
// mm8_pkg
// Shared types and constants for the 8x8 unsigned matrix multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

package mm8_pkg;

    // Input opcodes
    localparam logic [1:0] OP_WRITE_A = 2'd0;
    localparam logic [1:0] OP_WRITE_B = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam int SUM_W = 19;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Command queue between front and back
    localparam int CQ_DEPTH = 4;
    localparam int CQ_PW    = $clog2(CQ_DEPTH);
    localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] row;
        logic [2:0] col;
        logic [7:0] value;
    } in_word_t;

    typedef struct packed {
        logic [2:0]       out_row;
        logic [2:0]       out_col;
        logic [SUM_W-1:0] product_sum;
        logic             last_of_run;
    } out_word_t;

    typedef enum logic [1:0] {
        CMD_WRITE_A,
        CMD_WRITE_B,
        CMD_COMPUTE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [2:0] row;
        logic [2:0] col;
        logic [7:0] value;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_WAIT,
        ST_EMIT
    } back_state_t;

endpackage

`default_nettype wire

### hdl/mm8_front.sv
// ---------------------------------------------------------------------------
// mm8_front
// Accepts input words, drops no-ops and out-of-range writes, and queues
// the remaining commands for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module mm8_front
    import mm8_pkg::*;
#(
    parameter int DIM = 8
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_word_t item,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output cmd_t     cmd
);

    cmd_t             cq_mem [CQ_DEPTH];
    logic [CQ_PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_CW-1:0] count_reg, count_next;

    logic  keep;
    logic  in_range;
    cmd_t  cls_cmd;
    logic  enq;
    logic  deq;

    // Classify
    always_comb
    begin
        in_range      = (int'(item.row) < DIM) && (int'(item.col) < DIM);
        keep          = 1'b0;
        cls_cmd.kind  = CMD_COMPUTE;
        cls_cmd.row   = item.row;
        cls_cmd.col   = item.col;
        cls_cmd.value = item.value;
        unique case (item.op)
            OP_WRITE_A:
            begin
                keep         = in_range;
                cls_cmd.kind = CMD_WRITE_A;
            end
            OP_WRITE_B:
            begin
                keep         = in_range;
                cls_cmd.kind = CMD_WRITE_B;
            end
            OP_COMPUTE:
            begin
                keep         = 1'b1;
                cls_cmd.kind = CMD_COMPUTE;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign full      = (count_reg == CQ_CW'(CQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = cq_mem[rd_ptr_reg];
    assign enq       = push && !full && keep;
    assign deq       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = enq ? CQ_PW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = deq ? CQ_PW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (enq && !deq)
        begin
            count_next = CQ_CW'(count_reg + 1'b1);
        end
        else if (deq && !enq)
        begin
            count_next = CQ_CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            cq_mem[wr_ptr_reg] <= cls_cmd;
        end
    end

endmodule

`default_nettype wire

### hdl/mm8_back.sv
// ---------------------------------------------------------------------------
// mm8_back
// Holds the A and B stores, runs the multiply sequencer over a row of
// MAC cells and presents results through an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module mm8_back
    import mm8_pkg::*;
#(
    parameter int DIM = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_t      cmd,
    input  logic      pop,
    output logic      empty,
    output out_word_t result
);

    localparam int IW = $clog2(DIM);
    localparam int AW = $clog2(DIM * DIM);
    localparam int SW = $clog2(DIM * 65025 + 1);
    localparam int XW = (SW > SUM_W) ? SW : SUM_W;

    // Stores: A row-major bytes, B one word per row with a byte per column
    logic [7:0]            a_mem [DIM * DIM];
    logic [DIM-1:0][7:0]   b_mem [DIM];
    logic [DIM*DIM-1:0]    a_vld_reg;
    logic [DIM-1:0][DIM-1:0] b_vld_reg;

    logic [7:0]            a_rd_reg;
    logic [DIM-1:0][7:0]   b_rd_reg;
    logic                  a_rdv_reg;
    logic [DIM-1:0]        b_rdv_reg;

    back_state_t    state_reg, state_next;
    logic [IW-1:0]  i_reg, i_next;
    logic [IW-1:0]  k_reg, k_next;
    logic [IW-1:0]  j_reg, j_next;
    logic [AW-1:0]  a_ptr_reg, a_ptr_next;
    logic           mac_en_reg, mac_en_next;
    logic           mac_first_reg, mac_first_next;
    logic           out_vld_reg, out_vld_next;
    out_word_t      result_reg;

    logic [SW-1:0]  acc_reg [DIM];
    logic [15:0]    prod [DIM];
    logic [7:0]     a_eff;

    logic           wr_a;
    logic           wr_b;
    logic           rd_en;
    logic           push_out;
    logic           out_space;
    logic [AW-1:0]  wr_addr;
    logic [IW-1:0]  wr_row;
    logic [IW-1:0]  wr_col;
    logic [XW-1:0]  acc_x;
    out_word_t      emit_word;

    assign wr_addr   = AW'(int'(cmd.row) * DIM + int'(cmd.col));
    assign wr_row    = IW'(cmd.row);
    assign wr_col    = IW'(cmd.col);
    assign out_space = !out_vld_reg || pop;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        a_ptr_next     = a_ptr_reg;
        mac_en_next    = 1'b0;
        mac_first_next = 1'b0;
        cmd_ready      = 1'b0;
        wr_a           = 1'b0;
        wr_b           = 1'b0;
        rd_en          = 1'b0;
        push_out       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    unique case (cmd.kind)
                        CMD_WRITE_A:
                        begin
                            wr_a = 1'b1;
                        end
                        CMD_WRITE_B:
                        begin
                            wr_b = 1'b1;
                        end
                        CMD_COMPUTE:
                        begin
                            i_next     = '0;
                            k_next     = '0;
                            a_ptr_next = '0;
                            state_next = ST_MAC;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MAC:
            begin
                rd_en          = 1'b1;
                mac_en_next    = 1'b1;
                mac_first_next = (k_reg == '0);
                a_ptr_next     = AW'(a_ptr_reg + 1'b1);
                if (k_reg == IW'(DIM - 1))
                begin
                    k_next     = '0;
                    state_next = ST_WAIT;
                end
                else
                begin
                    k_next = IW'(k_reg + 1'b1);
                end
            end
            ST_WAIT:
            begin
                // last MAC of the row lands this cycle
                j_next     = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_space)
                begin
                    push_out = 1'b1;
                    if (j_reg == IW'(DIM - 1))
                    begin
                        j_next = '0;
                        if (i_reg == IW'(DIM - 1))
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            i_next     = IW'(i_reg + 1'b1);
                            state_next = ST_MAC;
                        end
                    end
                    else
                    begin
                        j_next = IW'(j_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (push_out)
        begin
            out_vld_next = 1'b1;
        end
        else if (pop)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            a_ptr_reg     <= '0;
            mac_en_reg    <= 1'b0;
            mac_first_reg <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
            a_ptr_reg     <= a_ptr_next;
            mac_en_reg    <= mac_en_next;
            mac_first_reg <= mac_first_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    // Entry valid bits: an unwritten entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= '0;
            b_vld_reg <= '0;
            a_rdv_reg <= 1'b0;
            b_rdv_reg <= '0;
        end
        else
        begin
            if (wr_a)
            begin
                a_vld_reg[wr_addr] <= 1'b1;
            end
            if (wr_b)
            begin
                b_vld_reg[wr_row][wr_col] <= 1'b1;
            end
            if (rd_en)
            begin
                a_rdv_reg <= a_vld_reg[a_ptr_reg];
                b_rdv_reg <= b_vld_reg[k_reg];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            a_mem[wr_addr] <= cmd.value;
        end
        if (rd_en)
        begin
            a_rd_reg <= a_mem[a_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_b)
        begin
            b_mem[wr_row][wr_col] <= cmd.value;
        end
        if (rd_en)
        begin
            b_rd_reg <= b_mem[k_reg];
        end
    end

    // MAC cells, one per output column
    assign a_eff = a_rdv_reg ? a_rd_reg : 8'd0;

    always_comb
    begin
        for (int c = 0; c < DIM; c++)
        begin
            prod[c] = 16'(a_eff) * 16'(b_rdv_reg[c] ? b_rd_reg[c] : 8'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mac_en_reg)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                acc_reg[c] <= (mac_first_reg ? SW'(0) : acc_reg[c]) + SW'(prod[c]);
            end
        end
    end

    // Result formatting with saturation at the field width
    always_comb
    begin
        acc_x                 = XW'(acc_reg[j_reg]);
        emit_word.out_row     = 3'(i_reg);
        emit_word.out_col     = 3'(j_reg);
        emit_word.product_sum = (acc_x > XW'(SUM_MAX)) ? SUM_MAX : acc_x[SUM_W-1:0];
        emit_word.last_of_run = (i_reg == IW'(DIM - 1)) && (j_reg == IW'(DIM - 1));
    end

    always_ff @(posedge clk)
    begin
        if (push_out)
        begin
            result_reg <= emit_word;
        end
    end

    assign empty  = !out_vld_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### hdl/matrix_multiply_8x8_u8.sv
// ---------------------------------------------------------------------------
// matrix_multiply_8x8_u8
// Unsigned 8-bit DIM x DIM matrix multiplier with queue-style ports.
// ---------------------------------------------------------------------------
// Usage:
//   Input words go in on item with push; a word is taken on a rising edge
//   with push high and full low. op 0 loads A[row][col], op 1 loads B[row][col],
//   op 2 starts a product run; op 3 and out-of-range loads are dropped.
//   Results come out on result while empty is low, oldest first, and leave
//   on a rising edge with pop high. A run gives DIM*DIM words in row-major
//   order, the final one marked with last_of_run.
// Timing:
//   The back end takes a load while idle and stays idle. In a run, each
//   row reads one A byte and one B row word per cycle into DIM MAC cells
//   (ST_MAC), then waits while the last products settle (ST_WAIT), then
//   emits the row one entry at a time as the output register frees (ST_EMIT).
// Reset and stalls:
//   Reset empties the command queue and output register and marks every
//   store entry unwritten, so both matrices read as zero. A stalled
//   receiver holds the run in place; the four-deep command queue keeps
//   taking words until it fills, then full rises.
// ---------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_8x8_u8
    import mm8_pkg::*;
#(
    parameter int DIM = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_word_t  item,
    input  logic      pop,
    output logic      empty,
    output out_word_t result
);

    // Front to back command handoff
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    // Front: classify and queue
    mm8_front #(
        .DIM (DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Back: stores, MAC sequencer, output register
    mm8_back #(
        .DIM (DIM)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

`default_nettype wire

### hdl/mm8_checker.sv
// ---------------------------------------------------------------------------
// mm8_checker
// Port-level checks for the matrix multiplier, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mm8_checker
    import mm8_pkg::*;
#(
    parameter int DIM = 8
)
(
    input logic      clk,
    input logic      rst_n,
    input logic      push,
    input logic      full,
    input logic      pop,
    input logic      empty,
    input out_word_t result
);

    localparam int SUM_BOUND = (DIM * 65025 > int'(SUM_MAX)) ? int'(SUM_MAX) : DIM * 65025;

    logic waiting;
    logic last_pos;
    logic sum_ok;

    assign waiting  = !empty && !pop;
    assign last_pos = (result.out_row == 3'(DIM - 1)) && (result.out_col == 3'(DIM - 1));
    assign sum_ok   = (int'(result.product_sum) <= SUM_BOUND);

    // a shown result stays until taken
    `ASSERT_NEXT(a_hold_word, clk, rst_n, waiting, !empty)
    `ASSERT_NEXT(a_hold_data, clk, rst_n, waiting, $stable(result))
    // run end only on the bottom-right entry
    `ASSERT_IMPL(a_last_pos, clk, rst_n, !empty && result.last_of_run, last_pos)
    // no dot product exceeds DIM full-scale terms
    `ASSERT_IMPL(a_sum_bound, clk, rst_n, !empty, sum_ok)
    // full only rises after a pushed word
    `ASSERT_NEXT(a_full_rise, clk, rst_n, !full && !push, !full)

endmodule

bind matrix_multiply_8x8_u8 mm8_checker #(
    .DIM (DIM)
) u_mm8_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .pop    (pop),
    .empty  (empty),
    .result (result)
);

`default_nettype wire
